// File: rtl/joystick_deadzone_normalizer_assert.svh
// assertion macros for the joystick dead-zone normaliser
// expects clk and rst_n in the scope of the module that uses them
`ifndef JOYSTICK_DEADZONE_NORMALIZER_ASSERT_SVH
`define JOYSTICK_DEADZONE_NORMALIZER_ASSERT_SVH

// same-cycle implication, held off during reset
`define JDN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define JDN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/jdn_pkg.sv
// shared types, constants and helpers for the joystick dead-zone normaliser
// no dependencies
package jdn_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_BITS    = SAMPLE_BITS + 1;
  localparam int PCT_BITS    = 7;
  localparam int NUM_BITS    = SAMPLE_BITS + PCT_BITS;
  localparam int CNT_BITS    = $clog2(SAMPLE_BITS + 1);
  localparam int CFG_BITS    = 8;

  localparam logic [CFG_BITS-1:0] DZ_DIV_RESET = 8'd20;
  localparam logic [PCT_BITS-1:0] PCT_FULL     = 7'd100;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MAX_BITS-1:0]    wide_t;
  typedef logic [NUM_BITS-1:0]    num_t;
  typedef logic signed [7:0]      pct_t;

  typedef struct packed {
    sample_t raw_x;
    sample_t raw_y;
    logic    button_up;
  } in_item_t;

  typedef struct packed {
    pct_t drive_a;
    pct_t drive_b;
    logic brake;
  } out_item_t;

  // divider operation: centre over divisor, or percent with a short quotient
  typedef enum logic {
    DIV_CAL = 1'b0,
    DIV_PCT = 1'b1
  } div_op_t;

  typedef struct packed {
    logic    start;
    div_op_t op;
    num_t    num;
    wide_t   den;
  } div_req_t;

  typedef struct packed {
    logic    busy;
    logic    done;
    sample_t quo;
  } div_rsp_t;

  // constant multiply by one hundred as shifts and adds
  function automatic num_t times100(sample_t v);
    num_t w;
    w = {{PCT_BITS{1'b0}}, v};
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

endpackage

// File: rtl/joystick_deadzone_normalizer.sv
// Joystick dead-zone normaliser. The first transaction after reset calibrates the
// block and gives no result: each sample becomes its axis centre, the axis maximum
// twice the centre, and the dead-zone half width centre / dz_div_r (0 acts as 1).
// Every later transaction raises an exceeded maximum and gives one result with each
// axis in -100..100 and brake = !button_up. All division runs on one shared restoring
// divider at one quotient bit per cycle, axis by axis; an axis in the dead zone or on
// a flat span skips the divider, and a new transaction is taken only once the last one
// has left the sequencer. A finished result waits in the output register while the
// next transaction is taken; a result still held there when the next one is ready
// holds that one in S_OUT until out_ready.
// Depends on jdn_pkg, jdn_div and joystick_deadzone_normalizer_assert.svh.
`include "joystick_deadzone_normalizer_assert.svh"

module joystick_deadzone_normalizer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  jdn_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output jdn_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [jdn_pkg::CFG_BITS-1:0] cfg_wdata
);
  import jdn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIV   = 5'b00100,
    S_NEXT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic                axis_r, axis_nxt;
  logic                cal_r, cal_nxt;
  logic [CFG_BITS-1:0] dz_div_r;
  sample_t             centre_r [2];
  sample_t             centre_nxt [2];
  wide_t               max_r [2];
  wide_t               max_nxt [2];
  sample_t             null_r [2];
  sample_t             null_nxt [2];
  sample_t             raw_r [2];
  sample_t             raw_nxt [2];
  pct_t                res_r [2];
  pct_t                res_nxt [2];
  logic                brake_r, brake_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  sample_t             raw, mid, dz, low_edge;
  wide_t               top, high_edge, span, above_diff, cal_den;
  logic                below, above;
  logic [PCT_BITS-1:0] quo7;

  jdn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // dead-zone divisor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_div_r <= DZ_DIV_RESET;
    end else if (cfg_we) begin
      dz_div_r <= cfg_wdata;
    end
  end

  // edges and region of the axis being worked on
  always_comb begin
    raw        = raw_r[axis_r];
    mid        = centre_r[axis_r];
    top        = max_r[axis_r];
    dz         = null_r[axis_r];
    low_edge   = mid - dz;
    high_edge  = {1'b0, mid} + {1'b0, dz};
    span       = top - high_edge;
    above_diff = {1'b0, raw} - high_edge;
    below      = raw < low_edge;
    above      = {1'b0, raw} > high_edge;
    cal_den    = (dz_div_r == '0) ? wide_t'(1) : {{(MAX_BITS-CFG_BITS){1'b0}}, dz_div_r};
    quo7       = div_rsp.quo[PCT_BITS-1:0];
  end

  // divider request
  always_comb begin
    div_req.start = (state_r == S_SETUP) &&
                    (!cal_r || below || (above && (span != '0)));
    if (!cal_r) begin
      div_req.op  = DIV_CAL;
      div_req.num = {{PCT_BITS{1'b0}}, raw};
      div_req.den = cal_den;
    end else if (below) begin
      div_req.op  = DIV_PCT;
      div_req.num = times100(raw);
      div_req.den = {1'b0, low_edge};
    end else begin
      div_req.op  = DIV_PCT;
      div_req.num = times100(above_diff[SAMPLE_BITS-1:0]);
      div_req.den = span;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cal_nxt       = cal_r;
    centre_nxt    = centre_r;
    max_nxt       = max_r;
    null_nxt      = null_r;
    raw_nxt       = raw_r;
    res_nxt       = res_r;
    brake_nxt     = brake_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          raw_nxt[0] = in_data.raw_x;
          raw_nxt[1] = in_data.raw_y;
          brake_nxt  = !in_data.button_up;
          axis_nxt   = 1'b0;
          if (!cal_r) begin
            centre_nxt[0] = in_data.raw_x;
            centre_nxt[1] = in_data.raw_y;
            max_nxt[0]    = {in_data.raw_x, 1'b0};
            max_nxt[1]    = {in_data.raw_y, 1'b0};
          end else begin
            // raise an exceeded maximum before mapping
            if ({1'b0, in_data.raw_x} > max_r[0]) begin
              max_nxt[0] = {1'b0, in_data.raw_x};
            end
            if ({1'b0, in_data.raw_y} > max_r[1]) begin
              max_nxt[1] = {1'b0, in_data.raw_y};
            end
          end
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (div_req.start) begin
          state_nxt = S_DIV;
        end else if (above) begin
          res_nxt[axis_r] = {1'b0, PCT_FULL};
          state_nxt       = S_NEXT;
        end else begin
          // inside the dead zone
          res_nxt[axis_r] = '0;
          state_nxt       = S_NEXT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (!cal_r) begin
            null_nxt[axis_r] = div_rsp.quo;
          end else if (below) begin
            res_nxt[axis_r] = {1'b0, quo7} - {1'b0, PCT_FULL};
          end else if (quo7 > PCT_FULL) begin
            res_nxt[axis_r] = {1'b0, PCT_FULL};
          end else begin
            res_nxt[axis_r] = {1'b0, quo7};
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_SETUP;
        end else if (!cal_r) begin
          cal_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.drive_a = res_r[0];
          out_data_nxt.drive_b = res_r[1];
          out_data_nxt.brake   = brake_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      cal_r       <= 1'b0;
      out_valid_r <= 1'b0;
      centre_r    <= '{default: '0};
      max_r       <= '{default: '0};
      null_r      <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      cal_r       <= cal_nxt;
      out_valid_r <= out_valid_nxt;
      centre_r    <= centre_nxt;
      max_r       <= max_nxt;
      null_r      <= null_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    res_r      <= res_nxt;
    brake_r    <= brake_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks on the sequencer and stored calibration
  `JDN_ASSERT_IMP(a_ready_div_idle, in_ready, !div_rsp.busy)
  `JDN_ASSERT_IMP(a_done_in_div, div_rsp.done, state_r == S_DIV)
  `JDN_ASSERT_NXT(a_cal_sticky, cal_r, cal_r)
  `JDN_ASSERT_IMP(a_null_in_centre, cal_r, (null_r[0] <= centre_r[0]) && (null_r[1] <= centre_r[1]))
  `JDN_ASSERT_IMP(a_out_after_cal, state_r == S_OUT, cal_r)

endmodule

// File: rtl/jdn_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on jdn_pkg
module jdn_div (
  input  logic             clk,
  input  logic             rst_n,
  input  jdn_pkg::div_req_t req,
  output jdn_pkg::div_rsp_t rsp
);
  import jdn_pkg::*;

  logic                busy_r, busy_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  wide_t               rem_r, rem_nxt;
  wide_t               den_r, den_nxt;
  num_t                q_r, q_nxt;
  logic [MAX_BITS:0]   shifted;
  logic [MAX_BITS:0]   trial;

  // one trial subtraction per step
  always_comb begin
    shifted = {rem_r, q_r[NUM_BITS-1]};
    trial   = shifted - {1'b0, den_r};
  end

  // load and step
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      den_nxt  = req.den;
      if (req.op == DIV_CAL) begin
        // full-width quotient, remainder starts empty
        rem_nxt = '0;
        q_nxt   = {req.num[SAMPLE_BITS-1:0], {PCT_BITS{1'b0}}};
        cnt_nxt = CNT_BITS'(SAMPLE_BITS);
      end else begin
        // quotient known below 128, so the top bits already sit under the divisor
        rem_nxt = {1'b0, req.num[NUM_BITS-1:PCT_BITS]};
        q_nxt   = {req.num[PCT_BITS-1:0], {SAMPLE_BITS{1'b0}}};
        cnt_nxt = CNT_BITS'(PCT_BITS);
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        if (!trial[MAX_BITS]) begin
          rem_nxt = trial[MAX_BITS-1:0];
          q_nxt   = {q_r[NUM_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[MAX_BITS-1:0];
          q_nxt   = {q_r[NUM_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  // quotient sits in the low bits once the count runs out
  always_comb begin
    rsp.busy = busy_r;
    rsp.done = busy_r && (cnt_r == '0);
    rsp.quo  = q_r[SAMPLE_BITS-1:0];
  end

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for joystick_deadzone_normalizer: calibration, dead-zone mapping
// and brake, with random idling on both channels and divisor writes between phases
// depends on jdn_pkg and the rtl of joystick_deadzone_normalizer
`timescale 1ns / 1ps

module tb;
  import jdn_pkg::*;

  // tracks calibration state per axis and the queue of expected drive commands
  class drive_scoreboard;
    bit            calibrated;
    int            divisor;
    int            mid[2];
    int            top[2];
    int            dead[2];
    out_item_t     expected_drive[$];
    int            errors;

    function new();
      calibrated = 1'b0;
      divisor    = int'(DZ_DIV_RESET);
      errors     = 0;
      for (int a = 0; a < 2; a++) begin
        mid[a]  = 0;
        top[a]  = 0;
        dead[a] = 0;
      end
    endfunction

    function void set_divisor(logic [CFG_BITS-1:0] v);
      divisor = int'(v);
    endfunction

    // percent for one axis from the calibrated centre, maximum and dead zone
    function int axis_to_percent(int raw, int a);
      int lo_edge;
      int hi_edge;
      int span;
      int q;
      lo_edge = mid[a] - dead[a];
      hi_edge = mid[a] + dead[a];
      if (raw < lo_edge) begin
        return (raw * 100) / lo_edge - 100;
      end
      if (raw > hi_edge) begin
        span = top[a] - hi_edge;
        if (span == 0) begin
          return 100;
        end
        q = ((raw - hi_edge) * 100) / span;
        return (q > 100) ? 100 : q;
      end
      return 0;
    endfunction

    // accepted input transaction: calibrate once, then queue the drive command
    function void note_sample(in_item_t it);
      int        raw[2];
      int        d;
      out_item_t cmd;
      raw[0] = int'(it.raw_x);
      raw[1] = int'(it.raw_y);
      if (!calibrated) begin
        d = (divisor == 0) ? 1 : divisor;
        for (int a = 0; a < 2; a++) begin
          mid[a]  = raw[a];
          top[a]  = (raw[a] * 2) & ((1 << MAX_BITS) - 1);
          dead[a] = raw[a] / d;
        end
        calibrated = 1'b1;
        return;
      end
      for (int a = 0; a < 2; a++) begin
        if (raw[a] > top[a]) top[a] = raw[a];
      end
      cmd.drive_a = pct_t'(axis_to_percent(raw[0], 0));
      cmd.drive_b = pct_t'(axis_to_percent(raw[1], 1));
      cmd.brake   = ~it.button_up;
      expected_drive.push_back(cmd);
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_drive(out_item_t got);
      out_item_t exp_cmd;
      if (expected_drive.size() == 0) begin
        $error("unexpected result: drive_a %0d drive_b %0d brake %0b",
               got.drive_a, got.drive_b, got.brake);
        errors++;
        return;
      end
      exp_cmd = expected_drive.pop_front();
      if (got.drive_a !== exp_cmd.drive_a) begin
        $error("drive_a expected %0d actual %0d", exp_cmd.drive_a, got.drive_a);
        errors++;
      end
      if (got.drive_b !== exp_cmd.drive_b) begin
        $error("drive_b expected %0d actual %0d", exp_cmd.drive_b, got.drive_b);
        errors++;
      end
      if (got.brake !== exp_cmd.brake) begin
        $error("brake expected %0b actual %0b", exp_cmd.brake, got.brake);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_WAIT  = 40;
  localparam int SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  // no idling on either side while set
  bit                  calm;
  int                  cycles;
  drive_scoreboard     sb;

  joystick_deadzone_normalizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_drive(out_data);
    end
  end

  function automatic sample_t to_sample(int v);
    if (v < 0) return sample_t'(0);
    if (v > SAMPLE_TOP) return sample_t'(SAMPLE_TOP);
    return sample_t'(v);
  endfunction

  // points of interest on one axis: rails, dead-zone edges, centre and maximum
  function automatic sample_t probe_point(int a, int k);
    case (k)
      0:       return to_sample(0);
      1:       return to_sample(SAMPLE_TOP);
      2:       return to_sample(sb.mid[a] - sb.dead[a] - 1);
      3:       return to_sample(sb.mid[a] - sb.dead[a]);
      4:       return to_sample(sb.mid[a]);
      5:       return to_sample(sb.mid[a] + sb.dead[a]);
      6:       return to_sample(sb.mid[a] + sb.dead[a] + 1);
      default: return to_sample(sb.top[a]);
    endcase
  endfunction

  // random sample, weighted towards the dead-zone edges and the rails
  function automatic sample_t pick_raw(int a);
    int spread;
    spread = 2 * sb.dead[a] + 8;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom_range(0, SAMPLE_TOP));
      4, 5, 6:    return to_sample(sb.mid[a] - sb.dead[a] - 4
                                   + int'($urandom_range(0, spread)));
      7:          return to_sample(sb.top[a] - int'($urandom_range(0, 8)));
      8:          return sample_t'($urandom_range(0, 15));
      default:    return sample_t'($urandom_range(SAMPLE_TOP - 15, SAMPLE_TOP));
    endcase
  endfunction

  // one input transaction; entered and left at a falling edge
  task automatic push_sample(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write, then write enable held low so back-to-back writes stay apart
  task automatic write_divisor(input logic [CFG_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.set_divisor(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every expected result, then let the block go idle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.expected_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(input int count, input int calm_from, input int calm_to);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      calm         = (i >= calm_from) && (i < calm_to);
      it.raw_x     = pick_raw(0);
      it.raw_y     = pick_raw(1);
      it.button_up = 1'($urandom_range(0, 1));
      push_sample(it);
    end
    calm = 1'b0;
  endtask

  // main sequence
  initial begin
    in_item_t it;
    logic [CFG_BITS-1:0] cal_div;
    sb        = new();
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // divisor extremes, then the one in force at calibration
    write_divisor(8'd255);
    write_divisor(8'd0);
    case ($urandom_range(0, 4))
      0:       cal_div = 8'd0;
      1:       cal_div = 8'd1;
      2:       cal_div = 8'd255;
      3:       cal_div = DZ_DIV_RESET;
      default: cal_div = CFG_BITS'($urandom_range(1, 255));
    endcase
    write_divisor(cal_div);

    // calibrating transaction, centre now and then on a rail
    for (int a = 0; a < 2; a++) begin
      case ($urandom_range(0, 9))
        0:       it = '0;
        default: it = '0;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       it.raw_x = sample_t'(0);
      1:       it.raw_x = sample_t'(SAMPLE_TOP);
      default: it.raw_x = sample_t'($urandom_range(256, SAMPLE_TOP - 256));
    endcase
    case ($urandom_range(0, 9))
      0:       it.raw_y = sample_t'(0);
      1:       it.raw_y = sample_t'(SAMPLE_TOP);
      default: it.raw_y = sample_t'($urandom_range(256, SAMPLE_TOP - 256));
    endcase
    it.button_up = 1'($urandom_range(0, 1));
    push_sample(it);

    // directed points, each axis walked against the other in reverse
    for (int k = 0; k < 16; k++) begin
      it.raw_x     = probe_point(0, k % 8);
      it.raw_y     = probe_point(1, 7 - (k % 8));
      it.button_up = k[0];
      push_sample(it);
    end
    drain_block();

    // random phases with divisor writes between them, which must not disturb anything
    write_divisor(8'd1);
    random_phase(630, 0, 0);
    drain_block();
    write_divisor(8'd255);
    random_phase(630, 200, 420);
    drain_block();
    write_divisor(CFG_BITS'($urandom_range(0, 255)));
    random_phase(630, 0, 0);
    drain_block();

    if (sb.errors == 0 && sb.expected_drive.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/jdn_pkg.sv
rtl/jdn_div.sv
rtl/joystick_deadzone_normalizer.sv
tb/sv/tb.sv
